>>> design/sasa_pkg.sv
// ----------------------------------------------------------------------------
// sasa_pkg
// Shared types and constants of the sparse active score argmax block.
// ----------------------------------------------------------------------------
package sasa_pkg;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 128;

  // Input field widths
  localparam int ROW_F_W  = 6;
  localparam int COL_F_W  = 8;
  localparam int WGT_W    = 16;
  localparam int FAT_W    = 13;
  localparam int VAL_W    = 16;
  localparam int ENTRY_W  = 2 * WGT_W + FAT_W;

  // Output field widths
  localparam int STATUS_W = 2;
  localparam int IDX_F_W  = 6;
  localparam int BEST_F_W = 40;
  localparam int TGT_F_W  = 39;
  localparam int PSUM_F_W = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COLUMNS = 1'b1;
  localparam logic [6:0] OUT_ROWS_RESET   = 7'd64;
  localparam logic [8:0] IN_COLUMNS_RESET = 9'd256;

  // Request kinds (tuser on the input side)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PAIR = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_COL_OOR  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

  // Fixed point
  localparam logic [FAT_W-1:0] ONE_Q12 = 13'd4096;
  localparam int ROUND_SHIFT = 24;

  // Control tag that travels beside each product term
  typedef struct packed {
    logic vld;       // term present
    logic row_end;   // last term of a row
    logic last_row;  // last term of the whole scan
  } sasa_tag_t;

endpackage

>>> design/sasa_mac.sv
// ----------------------------------------------------------------------------
// sasa_mac
// Product, accumulate and round pipeline: one weight term per cycle in,
// one rounded Q.12 row score per row out.
// ----------------------------------------------------------------------------
module sasa_mac #(
  parameter int ACC_W = 55
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sasa_pkg::sasa_tag_t                tag_in,
  input  logic [sasa_pkg::ENTRY_W-1:0]       entry,
  input  logic signed [sasa_pkg::VAL_W-1:0]  value,
  output sasa_pkg::sasa_tag_t                tag_out,
  output logic signed [ACC_W-1:0]            score
);
  import sasa_pkg::*;

  localparam int P1_W = WGT_W + 1 + FAT_W + 1;
  localparam int P2_W = P1_W + VAL_W;

  logic signed [WGT_W:0]     wsum;
  logic signed [FAT_W:0]     keep;
  logic signed [P1_W-1:0]    p1;
  logic signed [VAL_W-1:0]   v2;
  logic signed [P2_W-1:0]    p2;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   row_sum;
  sasa_tag_t                 tag2, tag3, tag4;

  // Combine slow and live weights, scale by the part of one not fatigued
  assign wsum = (WGT_W+1)'($signed(entry[WGT_W-1:0]))
              + (WGT_W+1)'($signed(entry[2*WGT_W-1:WGT_W]));
  assign keep = $signed({1'b0, ONE_Q12 - entry[ENTRY_W-1:2*WGT_W]});

  always_ff @(posedge clk) begin
    p1 <= P1_W'(wsum * keep);
    v2 <= value;
    p2 <= P2_W'(p1 * v2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2    <= '0;
      tag3    <= '0;
      tag4    <= '0;
      tag_out <= '0;
      acc     <= '0;
    end else begin
      tag2 <= tag_in;
      tag3 <= tag2;
      tag4 <= (tag3.vld && tag3.row_end) ? tag3 : '0;
      if (tag3.vld) begin
        if (tag3.row_end) begin
          acc <= '0;
        end else begin
          acc <= acc + ACC_W'(p2);
        end
      end
      tag_out <= tag4;
    end
  end

  always_ff @(posedge clk) begin
    if (tag3.vld && tag3.row_end) begin
      row_sum <= acc + ACC_W'(p2);
    end
    // Round half up to Q.12: the arithmetic shift is a floor
    score <= (row_sum + ACC_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  end

endmodule

>>> design/sparse_active_score_argmax.sv
// ----------------------------------------------------------------------------
// sparse_active_score_argmax
// Sparse matrix-vector score over a slow/live/fatigue weight store with argmax.
// ----------------------------------------------------------------------------
// A load or a non-last pair is accepted whenever it is offered while idle. A last
// pair is answered after an arm step, a scan that issues one term per cycle out
// of the weight memory read port (rows x pairs terms), and the active buffer
// read, weight read, product, accumulate and round registers. Throughput: one
// request per cycle between queries; input is held from a last pair until its
// result is registered, and arming waits for a pending result to leave. Reset
// clears the query state and the configuration registers; the weight store and active buffer are not cleared.
module sparse_active_score_argmax #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ACTIVE  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: row, col, slow_weight, live_weight, fatigue_level,
  //          active_value, target_row (from bit 0 up), zero pad
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sasa_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                 s_tlast,
  input  logic                                 s_tuser,   // cmd
  // m_tdata: top row, top score, clamped target row score, positive row total
  //          (from bit 0 up), zero pad
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sasa_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [sasa_pkg::STATUS_W-1:0]        m_tuser,   // status
  input  logic                                 cfg_we,
  input  logic [sasa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sasa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sasa_pkg::*;

  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int WDEPTH    = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int ACT_IDX_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int ACT_CNT_W = $clog2(MAX_ACTIVE + 1);
  localparam int ABUF_W    = COL_F_W + VAL_W;
  localparam int ACC_W     = 48 + ACT_CNT_W;
  localparam int SUM_W     = ACC_W + ROW_CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ARM   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // Request fields
  logic [ROW_F_W-1:0]       in_row;
  logic [COL_F_W-1:0]       in_col;
  logic [ENTRY_W-1:0]       in_entry;
  logic [FAT_W-1:0]         in_fat;
  logic [VAL_W-1:0]         in_val;
  logic [ROW_F_W-1:0]       in_target;

  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[13:6];
  assign in_fat    = (s_tdata[58:46] > ONE_Q12) ? ONE_Q12 : s_tdata[58:46];
  assign in_entry  = {in_fat, s_tdata[45:30], s_tdata[29:14]};
  assign in_val    = s_tdata[74:59];
  assign in_target = s_tdata[80:75];

  // Registers and control state
  logic [1:0]               state;
  logic [6:0]               out_rows;
  logic [8:0]               in_columns;
  logic [ACT_CNT_W-1:0]     pair_count;
  logic [STATUS_W-1:0]      error_seen;
  logic [ROW_F_W-1:0]       target_q;
  logic [ROW_CNT_W-1:0]     rows_eff;
  logic [ROW_W-1:0]         rows_m1;
  logic [ACT_IDX_W-1:0]     cnt_m1;
  logic [ROW_W-1:0]         scan_r;
  logic [ACT_IDX_W-1:0]     scan_j;

  logic                     accept;
  logic                     is_load;
  logic                     col_ok;
  logic                     has_room;
  logic [STATUS_W-1:0]      error_next;
  logic                     res_load;

  // Memories
  logic [ENTRY_W-1:0]       wmem [WDEPTH];
  logic [ABUF_W-1:0]        abuf [MAX_ACTIVE];
  logic [ABUF_W-1:0]        abuf_q;
  logic [ENTRY_W-1:0]       wmem_q;

  // Pipeline
  sasa_tag_t                tag0, tag_a, tag_b, tag_s;
  logic [ROW_W-1:0]         r_a;
  logic signed [VAL_W-1:0]  val_b;
  logic signed [ACC_W-1:0]  score;

  // Final compare stage
  logic [ROW_W-1:0]         fin_r;
  logic signed [ACC_W-1:0]  best;
  logic [ROW_W-1:0]         best_r;
  logic signed [ACC_W-1:0]  tscore;
  logic [SUM_W-1:0]         psum;
  logic signed [ACC_W-1:0]  best_next;
  logic [ROW_W-1:0]         best_r_next;
  logic signed [ACC_W-1:0]  tscore_next;
  logic [SUM_W-1:0]         psum_next;
  logic                     score_pos;

  // Result register
  logic [STATUS_W-1:0]      res_status;
  logic [IDX_F_W-1:0]       res_idx;
  logic [BEST_F_W-1:0]      res_best;
  logic [TGT_F_W-1:0]       res_tgt;
  logic [PSUM_F_W-1:0]      res_psum;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == CMD_LOAD);

  // Column bound and room in the active buffer for a pair
  assign col_ok   = ({1'b0, in_col} < in_columns) && (32'(in_col) < MAX_COLUMNS);
  assign has_room = 32'(pair_count) < MAX_ACTIVE;

  // First error of a query wins
  always_comb begin
    error_next = error_seen;
    if (error_seen == STAT_OK) begin
      if (!col_ok) begin
        error_next = STAT_COL_OOR;
      end else if (!has_room) begin
        error_next = STAT_OVERFLOW;
      end
    end
  end

  // Rows in use: zero acts as one, clamp at the store height
  always_comb begin
    if (out_rows == 7'd0) begin
      rows_eff = ROW_CNT_W'(1);
    end else if (32'(out_rows) > MAX_ROWS) begin
      rows_eff = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_CNT_W'(out_rows);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_rows   <= OUT_ROWS_RESET;
      in_columns <= IN_COLUMNS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_ROWS:   out_rows   <= cfg_data[6:0];
        REG_IN_COLUMNS: in_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Weight store: write on load, read one term per cycle during the scan
  always_ff @(posedge clk) begin
    if (accept && is_load && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLUMNS)) begin
      wmem[ADDR_W'(32'(in_row) * MAX_COLUMNS + 32'(in_col))] <= in_entry;
    end
    wmem_q <= wmem[ADDR_W'(32'(r_a) * MAX_COLUMNS + 32'(abuf_q[COL_F_W-1:0]))];
    val_b  <= $signed(abuf_q[ABUF_W-1:COL_F_W]);
  end

  // Active buffer: append in-range pairs, read by the scan index
  always_ff @(posedge clk) begin
    if (accept && !is_load && col_ok && has_room) begin
      abuf[pair_count[ACT_IDX_W-1:0]] <= {in_val, in_col};
    end
    abuf_q <= abuf[scan_j];
    r_a    <= scan_r;
  end

  // Issue tag for the term addressed this cycle
  always_comb begin
    tag0          = '0;
    tag0.vld      = (state == ST_SCAN);
    tag0.row_end  = (scan_j == cnt_m1);
    tag0.last_row = (scan_j == cnt_m1) && (scan_r == rows_m1);
  end

  // Load the result register on an error close or on the last row score
  assign res_load = ((state == ST_ARM) && (!m_tvalid || m_tready) && (error_seen != STAT_OK))
                  || ((state == ST_DRAIN) && tag_s.vld && tag_s.last_row);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pair_count   <= '0;
      error_seen   <= STAT_OK;
      tag_a        <= '0;
      tag_b        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      tag_a <= tag0;
      tag_b <= tag_a;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && !is_load) begin
            error_seen <= error_next;
            if (col_ok && has_room) begin
              pair_count <= pair_count + ACT_CNT_W'(1);
            end
            if (s_tlast) begin
              state    <= ST_ARM;
              target_q <= in_target;
            end
          end
        end
        ST_ARM: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            pair_count <= '0;
            error_seen <= STAT_OK;
            if (error_seen != STAT_OK) begin
              res_status <= error_seen;
              res_idx    <= '0;
              res_best   <= '0;
              res_tgt    <= '0;
              res_psum   <= '0;
              state      <= ST_IDLE;
            end else begin
              rows_m1 <= ROW_W'(rows_eff - ROW_CNT_W'(1));
              cnt_m1  <= ACT_IDX_W'(pair_count - ACT_CNT_W'(1));
              scan_r  <= '0;
              scan_j  <= '0;
              fin_r   <= '0;
              psum    <= '0;
              tscore  <= '0;
              best    <= '0;
              best_r  <= '0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // advance column then row; last term moves to drain
          if (scan_j == cnt_m1) begin
            scan_j <= '0;
            if (scan_r == rows_m1) begin
              state <= ST_DRAIN;
            end else begin
              scan_r <= scan_r + ROW_W'(1);
            end
          end else begin
            scan_j <= scan_j + ACT_IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (tag_s.vld) begin
            fin_r  <= fin_r + ROW_W'(1);
            best   <= best_next;
            best_r <= best_r_next;
            psum   <= psum_next;
            tscore <= tscore_next;
            if (tag_s.last_row) begin
              res_status <= STAT_OK;
              res_idx    <= IDX_F_W'(best_r_next);
              res_best   <= BEST_F_W'(best_next);
              res_tgt    <= TGT_F_W'(tscore_next);
              res_psum   <= PSUM_F_W'(psum_next);
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      // rows finished while still issuing
      if (state == ST_SCAN && tag_s.vld) begin
        fin_r  <= fin_r + ROW_W'(1);
        best   <= best_next;
        best_r <= best_r_next;
        psum   <= psum_next;
        tscore <= tscore_next;
      end
    end
  end

  sasa_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_b),
    .entry   (wmem_q),
    .value   (val_b),
    .tag_out (tag_s),
    .score   (score)
  );

  // Argmax, positive sum and target pick for the row leaving the pipeline
  always_comb begin
    score_pos   = (score > 0);
    best_next   = best;
    best_r_next = best_r;
    if (fin_r == '0 || score > best) begin
      best_next   = score;
      best_r_next = fin_r;
    end
    psum_next = score_pos ? psum + SUM_W'(unsigned'(score)) : psum;
    tscore_next = tscore;
    if (32'(fin_r) == 32'(target_q)) begin
      tscore_next = score_pos ? score : '0;
    end
  end

  assign m_tdata = {3'b000, res_psum, res_tgt, res_best, res_idx};
  assign m_tuser = res_status;

endmodule
